// File: hw/rtl/tet_pkg.sv
// ----------------------------------------------------------------------------
// Typed edge table package
// Shared types, codes and default sizes for the typed edge table block.
// ----------------------------------------------------------------------------
package tet_pkg;

	// Default sizes, used as parameter defaults on the top level.
	localparam int DEF_CAPACITY   = 32;
	localparam int DEF_NODE_BITS  = 16;
	localparam int DEF_ACTOR_BITS = 16;
	localparam int DEF_NUM_KINDS  = 9;

	// Fixed field widths of the request and response items.
	localparam int NODE_FIELD_W  = 16;
	localparam int KIND_W        = 4;
	localparam int ACTOR_FIELD_W = 16;
	localparam int TOTAL_W       = 6;
	localparam int SCAN_W        = 64;

	typedef enum logic [1:0] {
		OP_DECLARE = 2'd0,
		OP_HAS     = 2'd1,
		OP_REMOVE  = 2'd2,
		OP_QUERY   = 2'd3
	} tet_op_t;

	typedef enum logic [1:0] {
		STAT_OK     = 2'd0,
		STAT_MISS   = 2'd1,
		STAT_REJECT = 2'd2,
		STAT_FULL   = 2'd3
	} tet_status_t;

	typedef struct packed {
		tet_op_t                    req_type;
		logic [NODE_FIELD_W-1:0]    node_a;
		logic [KIND_W-1:0]          edge_kind;
		logic [NODE_FIELD_W-1:0]    node_b;
		logic [ACTOR_FIELD_W-1:0]   actor_id;
	} tet_req_t;

	typedef struct packed {
		tet_status_t                status;
		logic [NODE_FIELD_W-1:0]    neighbour;
		logic                       last;
		logic [TOTAL_W-1:0]         edge_total;
		logic [SCAN_W-1:0]          edges_examined;
	} tet_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_FIND,
		ST_SHIFT,
		ST_SCAN_COUNT,
		ST_TOTAL,
		ST_SCAN_EMIT,
		ST_EMIT_OK,
		ST_EMIT_MISS,
		ST_EMIT_REJ,
		ST_EMIT_FULL
	} tet_state_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic        latch;        // capture the request item
		logic        prime;        // restart the scan at the newest entry
		logic        advance;      // step the scan to the next older entry
		logic        scan_inc;     // count one examined entry
		logic        match_inc;    // count one query match
		logic        add_total;    // add the edge count to the scan counter
		logic        write_new;    // store the request as the newest edge
		logic        shift_start;  // begin closing the gap of a removed edge
		logic        shift_step;   // move one newer entry down by one place
		logic        count_dec;    // one edge fewer
		logic        emit;         // load the response register
		logic        emit_hit;     // response is a query neighbour
		tet_status_t emit_status;  // status of a single response
	} tet_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		tet_op_t op;
		logic    null_a;
		logic    null_b;
		logic    bad_kind;
		logic    full;
		logic    empty;
		logic    at_first;
		logic    at_end;
		logic    find_hit;
		logic    query_hit;
		logic    any_match;
		logic    shift_done;
		logic    last_hit;
		logic    out_free;
	} tet_stat_t;

endpackage

// File: hw/rtl/tet_stream_if.sv
// ----------------------------------------------------------------------------
// Typed edge table stream channel
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tet_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

// File: hw/rtl/tet_ctrl.sv
// ----------------------------------------------------------------------------
// Typed edge table controller
// Sequences decode, table scans, removal shifts and response emission.
// ----------------------------------------------------------------------------
module tet_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  tet_pkg::tet_stat_t stat,
	output tet_pkg::tet_cmd_t  cmd
);

	tet_pkg::tet_state_t state_q;
	tet_pkg::tet_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tet_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			tet_pkg::ST_IDLE: begin
				if (req_valid) state_d = tet_pkg::ST_DECODE;
			end
			tet_pkg::ST_DECODE: begin
				case (stat.op)
					tet_pkg::OP_DECLARE: begin
						if (stat.null_a || stat.null_b || stat.bad_kind) begin
							state_d = tet_pkg::ST_EMIT_REJ;
						end else if (stat.full) begin
							state_d = tet_pkg::ST_EMIT_FULL;
						end else begin
							state_d = tet_pkg::ST_EMIT_OK;
						end
					end
					tet_pkg::OP_HAS, tet_pkg::OP_REMOVE: begin
						if (stat.null_a || stat.null_b) begin
							state_d = tet_pkg::ST_EMIT_REJ;
						end else if (stat.empty) begin
							state_d = tet_pkg::ST_EMIT_MISS;
						end else begin
							state_d = tet_pkg::ST_SCAN_FIND;
						end
					end
					default: begin
						if (stat.null_a) begin
							state_d = tet_pkg::ST_EMIT_REJ;
						end else if (stat.empty) begin
							state_d = tet_pkg::ST_EMIT_MISS;
						end else begin
							state_d = tet_pkg::ST_SCAN_COUNT;
						end
					end
				endcase
			end
			tet_pkg::ST_SCAN_FIND: begin
				if (stat.find_hit) begin
					if (stat.op == tet_pkg::OP_REMOVE && !stat.at_first) begin
						state_d = tet_pkg::ST_SHIFT;
					end else begin
						state_d = tet_pkg::ST_EMIT_OK;
					end
				end else if (stat.at_end) begin
					state_d = tet_pkg::ST_EMIT_MISS;
				end
			end
			tet_pkg::ST_SHIFT: begin
				if (stat.shift_done) state_d = tet_pkg::ST_EMIT_OK;
			end
			tet_pkg::ST_SCAN_COUNT: begin
				if (stat.at_end) begin
					state_d = stat.any_match ? tet_pkg::ST_TOTAL : tet_pkg::ST_EMIT_MISS;
				end
			end
			tet_pkg::ST_TOTAL: begin
				state_d = tet_pkg::ST_SCAN_EMIT;
			end
			tet_pkg::ST_SCAN_EMIT: begin
				if (stat.query_hit && stat.out_free && stat.last_hit) begin
					state_d = tet_pkg::ST_IDLE;
				end
			end
			tet_pkg::ST_EMIT_OK, tet_pkg::ST_EMIT_MISS,
			tet_pkg::ST_EMIT_REJ, tet_pkg::ST_EMIT_FULL: begin
				if (stat.out_free) state_d = tet_pkg::ST_IDLE;
			end
			default: begin
				state_d = tet_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs.
	always_comb begin
		cmd       = '0;
		req_ready = 1'b0;
		case (state_q)
			tet_pkg::ST_IDLE: begin
				req_ready = 1'b1;
				cmd.latch = req_valid;
			end
			tet_pkg::ST_DECODE: begin
				case (stat.op)
					tet_pkg::OP_DECLARE: begin
						cmd.write_new = !(stat.null_a || stat.null_b || stat.bad_kind ||
							stat.full);
					end
					tet_pkg::OP_HAS, tet_pkg::OP_REMOVE: begin
						cmd.prime = !(stat.null_a || stat.null_b || stat.empty);
					end
					default: begin
						cmd.prime = !(stat.null_a || stat.empty);
					end
				endcase
			end
			tet_pkg::ST_SCAN_FIND: begin
				cmd.scan_inc = 1'b1;
				if (stat.find_hit) begin
					if (stat.op == tet_pkg::OP_REMOVE) begin
						cmd.count_dec   = stat.at_first;
						cmd.shift_start = !stat.at_first;
					end
				end else begin
					cmd.advance = !stat.at_end;
				end
			end
			tet_pkg::ST_SHIFT: begin
				cmd.shift_step = 1'b1;
				cmd.count_dec  = stat.shift_done;
			end
			tet_pkg::ST_SCAN_COUNT: begin
				cmd.scan_inc  = 1'b1;
				cmd.match_inc = stat.query_hit;
				cmd.advance   = !stat.at_end;
			end
			tet_pkg::ST_TOTAL: begin
				cmd.add_total = 1'b1;
				cmd.prime     = 1'b1;
			end
			tet_pkg::ST_SCAN_EMIT: begin
				if (stat.query_hit) begin
					cmd.emit     = stat.out_free;
					cmd.emit_hit = stat.out_free;
					cmd.advance  = stat.out_free;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			tet_pkg::ST_EMIT_OK: begin
				cmd.emit        = stat.out_free;
				cmd.emit_status = tet_pkg::STAT_OK;
			end
			tet_pkg::ST_EMIT_MISS: begin
				cmd.emit        = stat.out_free;
				cmd.emit_status = tet_pkg::STAT_MISS;
			end
			tet_pkg::ST_EMIT_REJ: begin
				cmd.emit        = stat.out_free;
				cmd.emit_status = tet_pkg::STAT_REJECT;
			end
			tet_pkg::ST_EMIT_FULL: begin
				cmd.emit        = stat.out_free;
				cmd.emit_status = tet_pkg::STAT_FULL;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

endmodule

// File: hw/rtl/tet_dp.sv
// ----------------------------------------------------------------------------
// Typed edge table datapath
// Edge memory, scan pointers, counters, match logic and response register.
// ----------------------------------------------------------------------------
module tet_dp #(
	parameter int CAPACITY   = tet_pkg::DEF_CAPACITY,
	parameter int NODE_BITS  = tet_pkg::DEF_NODE_BITS,
	parameter int ACTOR_BITS = tet_pkg::DEF_ACTOR_BITS,
	parameter int NUM_KINDS  = tet_pkg::DEF_NUM_KINDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  tet_pkg::tet_req_t req_data,
	input  tet_pkg::tet_cmd_t cmd,
	output tet_pkg::tet_stat_t stat,
	output logic              rsp_valid,
	output tet_pkg::tet_rsp_t rsp_data,
	input  logic              rsp_ready
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int KIND_W = tet_pkg::KIND_W;
	localparam logic [KIND_W:0] KIND_LIMIT = (KIND_W + 1)'(NUM_KINDS);

	typedef struct packed {
		logic [NODE_BITS-1:0]  a;
		logic [KIND_W-1:0]     kind;
		logic [NODE_BITS-1:0]  b;
		logic [ACTOR_BITS-1:0] actor;
	} entry_t;

	// Latched request.
	tet_pkg::tet_op_t      op_q;
	logic [NODE_BITS-1:0]  a_q;
	logic [KIND_W-1:0]     kind_q;
	logic [NODE_BITS-1:0]  b_q;
	logic [ACTOR_BITS-1:0] actor_q;

	// Table state and scan pointers.
	entry_t                mem_q [CAPACITY];
	entry_t                rd_q;
	logic [CNT_W-1:0]      count_q;
	logic [IDX_W-1:0]      idx_q;
	logic [IDX_W-1:0]      sp_q;
	logic [CNT_W-1:0]      nmatch_q;
	logic [CNT_W-1:0]      emitted_q;
	logic [tet_pkg::SCAN_W-1:0] scan_q;

	logic                  out_valid_q;
	tet_pkg::tet_rsp_t     out_q;

	logic [CNT_W-1:0]      last_pos;
	logic [CNT_W-1:0]      phys_cur_w;
	logic [IDX_W-1:0]      phys_cur;
	logic [IDX_W-1:0]      rd_addr;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_addr;
	entry_t                wr_data;
	entry_t                new_entry;
	logic                  out_free;
	logic [NODE_BITS-1:0]  far_node;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q    <= req_data.req_type;
			a_q     <= NODE_BITS'(req_data.node_a);
			kind_q  <= req_data.edge_kind;
			b_q     <= NODE_BITS'(req_data.node_b);
			actor_q <= ACTOR_BITS'(req_data.actor_id);
		end
	end

	// Entries sit oldest first in memory: the newest edge is at count - 1.
	assign last_pos   = count_q - CNT_W'(1);
	assign phys_cur_w = last_pos - CNT_W'(idx_q);
	assign phys_cur   = phys_cur_w[IDX_W-1:0];

	always_comb begin
		if (cmd.shift_start) begin
			rd_addr = phys_cur + IDX_W'(1);
		end else if (cmd.shift_step) begin
			rd_addr = sp_q + IDX_W'(1);
		end else if (cmd.prime) begin
			rd_addr = last_pos[IDX_W-1:0];
		end else if (cmd.advance) begin
			rd_addr = phys_cur - IDX_W'(1);
		end else begin
			rd_addr = phys_cur;
		end
	end

	assign new_entry = '{a: a_q, kind: kind_q, b: b_q, actor: actor_q};
	assign wr_en     = cmd.write_new || cmd.shift_step;
	assign wr_addr   = cmd.write_new ? count_q[IDX_W-1:0] : sp_q - IDX_W'(1);
	assign wr_data   = cmd.write_new ? new_entry : rd_q;

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wr_addr] <= wr_data;
		rd_q <= mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			scan_q    <= '0;
			idx_q     <= '0;
			sp_q      <= '0;
			nmatch_q  <= '0;
			emitted_q <= '0;
		end else begin
			if (cmd.write_new) begin
				count_q <= count_q + CNT_W'(1);
			end else if (cmd.count_dec) begin
				count_q <= count_q - CNT_W'(1);
			end
			if (cmd.scan_inc || cmd.add_total) begin
				scan_q <= scan_q + (cmd.add_total ? tet_pkg::SCAN_W'(count_q)
					: tet_pkg::SCAN_W'(1));
			end
			if (cmd.prime) begin
				idx_q <= '0;
			end else if (cmd.advance) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (cmd.shift_start) begin
				sp_q <= phys_cur + IDX_W'(1);
			end else if (cmd.shift_step) begin
				sp_q <= sp_q + IDX_W'(1);
			end
			if (cmd.latch) begin
				nmatch_q  <= '0;
				emitted_q <= '0;
			end else begin
				if (cmd.match_inc) nmatch_q <= nmatch_q + CNT_W'(1);
				if (cmd.emit_hit) emitted_q <= emitted_q + CNT_W'(1);
			end
		end
	end

	assign far_node = (rd_q.a == a_q) ? rd_q.b : rd_q.a;
	assign out_free = !out_valid_q || rsp_ready;

	always_comb begin
		stat.op         = op_q;
		stat.null_a     = (a_q == '0);
		stat.null_b     = (b_q == '0);
		stat.bad_kind   = ({1'b0, kind_q} >= KIND_LIMIT);
		stat.full       = (count_q == CNT_W'(CAPACITY));
		stat.empty      = (count_q == '0);
		stat.at_first   = (idx_q == '0);
		stat.at_end     = (CNT_W'(idx_q) == last_pos);
		stat.find_hit   = (rd_q.a == a_q) && (rd_q.kind == kind_q) && (rd_q.b == b_q);
		stat.query_hit  = (rd_q.kind == kind_q) &&
			((rd_q.actor == '0) || (rd_q.actor == actor_q)) &&
			((rd_q.a == a_q) || (rd_q.b == a_q));
		stat.any_match  = (nmatch_q != '0) || stat.query_hit;
		stat.shift_done = (CNT_W'(sp_q) == last_pos);
		stat.last_hit   = ((emitted_q + CNT_W'(1)) == nmatch_q);
		stat.out_free   = out_free;
	end

	// Response register: one result waits here while the next is worked on.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_q.status         <= cmd.emit_hit ? tet_pkg::STAT_OK : cmd.emit_status;
			out_q.neighbour      <= cmd.emit_hit ? tet_pkg::NODE_FIELD_W'(far_node) : '0;
			out_q.last           <= cmd.emit_hit ? stat.last_hit : 1'b1;
			out_q.edge_total     <= tet_pkg::TOTAL_W'(count_q);
			out_q.edges_examined <= scan_q;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("edge count above capacity");

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> out_free)
		else $error("response loaded while the previous one is still held");

	a_no_insert_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.write_new |-> (count_q != CNT_W'(CAPACITY)))
		else $error("insert into a full table");

	a_scan_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.scan_inc || cmd.add_total) |=> $stable(scan_q))
		else $error("scan counter moved without a scan command");

endmodule

// File: hw/rtl/typed_edge_table.sv
// ----------------------------------------------------------------------------
// Typed edge table
// Bounded newest-first table of typed edges with declare, has, remove and
// neighbour query requests.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Payload    | Items per request
//  --------+-----------+------------+-------------------------------------
//  req     | in        | tet_req_t  | one
//  rsp     | out       | tet_rsp_t  | one, or one per query match
//
// A request is taken only while the block is idle. Declare, and any rejected
// or trivially missed request, goes from decode to an emit state that loads
// its response. Has and remove scan the entries from the newest; a remove that
// hits an older entry then moves each newer entry down one place.
// A query first scans every stored edge to count its matches, then scans
// again from the newest to the last match, one entry per cycle through the
// single read port of the edge memory while the response side does not stall.
// The next request can be taken in the cycle after the last response is loaded.
// Reset clears the edge count, the scan counter and all control state; the
// memory needs no clearing because only entries below the count are read.
// A stalled response side holds the scan on the current entry.
module typed_edge_table #(
	parameter int CAPACITY   = tet_pkg::DEF_CAPACITY,
	parameter int NODE_BITS  = tet_pkg::DEF_NODE_BITS,
	parameter int ACTOR_BITS = tet_pkg::DEF_ACTOR_BITS,
	parameter int NUM_KINDS  = tet_pkg::DEF_NUM_KINDS
) (
	input  logic          clk,
	input  logic          arst_n,
	tet_stream_if.sink    req,
	tet_stream_if.source  rsp
);

	// The controller only sees status flags; the datapath owns all storage.
	tet_pkg::tet_cmd_t  cmd;
	tet_pkg::tet_stat_t stat;

	tet_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	tet_dp #(
		.CAPACITY   (CAPACITY),
		.NODE_BITS  (NODE_BITS),
		.ACTOR_BITS (ACTOR_BITS),
		.NUM_KINDS  (NUM_KINDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_data  (req.payload),
		.cmd       (cmd),
		.stat      (stat),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.payload),
		.rsp_ready (rsp.ready)
	);

endmodule

// File: bench/tet_rsp_checker.sv
// ----------------------------------------------------------------------------
// Typed edge table response checker
// Watches the request and response channels of the typed edge table. It keeps
// its own copy of the edge table, works out the responses due for each
// accepted request and compares every accepted response field by field.
// ----------------------------------------------------------------------------
module tet_rsp_checker #(
	parameter int CAPACITY  = tet_pkg::DEF_CAPACITY,
	parameter int NUM_KINDS = tet_pkg::DEF_NUM_KINDS
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic              req_ready,
	input  tet_pkg::tet_req_t req_item,
	input  logic              rsp_valid,
	input  logic              rsp_ready,
	input  tet_pkg::tet_rsp_t rsp_item,
	output int                mismatches,
	output int                rsp_due,
	output int                rsp_seen,
	output int                peak_fill
);

	typedef struct packed {
		logic [tet_pkg::NODE_FIELD_W-1:0]  a;
		logic [tet_pkg::KIND_W-1:0]        kind;
		logic [tet_pkg::NODE_FIELD_W-1:0]  b;
		logic [tet_pkg::ACTOR_FIELD_W-1:0] actor;
	} arc_t;

	// Copy of the table, newest entry at index 0.
	arc_t        arc_copy [CAPACITY];
	int          arc_num;
	logic [63:0] scan_total;

	// Responses still owed by the block, oldest first.
	tet_pkg::tet_rsp_t due_q[$];

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (want !== got) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic apply_request(input tet_pkg::tet_req_t r);
		tet_pkg::tet_rsp_t                res;
		logic [tet_pkg::NODE_FIELD_W-1:0] hits[$];
		int                               idx;
		int                               i;
		res = '0;
		res.status = tet_pkg::STAT_OK;
		res.last = 1'b1;
		idx = -1;
		case (r.req_type)
			tet_pkg::OP_DECLARE: begin
				if (r.node_a == '0 || r.node_b == '0 || r.edge_kind >= NUM_KINDS) begin
					res.status = tet_pkg::STAT_REJECT;
				end else if (arc_num >= CAPACITY) begin
					res.status = tet_pkg::STAT_FULL;
				end else begin
					for (i = arc_num; i > 0; i--)
						arc_copy[i] = arc_copy[i-1];
					arc_copy[0] = '{r.node_a, r.edge_kind, r.node_b, r.actor_id};
					arc_num++;
				end
			end
			tet_pkg::OP_HAS, tet_pkg::OP_REMOVE: begin
				if (r.node_a == '0 || r.node_b == '0) begin
					res.status = tet_pkg::STAT_REJECT;
				end else begin
					for (i = 0; i < arc_num && idx < 0; i++) begin
						scan_total++;
						if (arc_copy[i].a == r.node_a && arc_copy[i].kind == r.edge_kind &&
								arc_copy[i].b == r.node_b)
							idx = i;
					end
					if (idx < 0) begin
						res.status = tet_pkg::STAT_MISS;
					end else if (r.req_type == tet_pkg::OP_REMOVE) begin
						for (i = idx; i + 1 < arc_num; i++)
							arc_copy[i] = arc_copy[i+1];
						arc_num--;
					end
				end
			end
			default: begin
				if (r.node_a == '0) begin
					res.status = tet_pkg::STAT_REJECT;
				end else begin
					for (i = 0; i < arc_num; i++) begin
						scan_total++;
						if (arc_copy[i].kind == r.edge_kind &&
								(arc_copy[i].actor == '0 || arc_copy[i].actor == r.actor_id)) begin
							if (arc_copy[i].a == r.node_a)
								hits.push_back(arc_copy[i].b);
							else if (arc_copy[i].b == r.node_a)
								hits.push_back(arc_copy[i].a);
						end
					end
					if (hits.size() == 0)
						res.status = tet_pkg::STAT_MISS;
					else
						scan_total += 64'(arc_num);
				end
			end
		endcase
		res.edge_total = arc_num[tet_pkg::TOTAL_W-1:0];
		res.edges_examined = scan_total;
		if (hits.size() == 0) begin
			due_q.push_back(res);
		end else begin
			for (i = 0; i < hits.size(); i++) begin
				res.neighbour = hits[i];
				res.last = (i == hits.size() - 1);
				due_q.push_back(res);
			end
		end
		if (arc_num > peak_fill)
			peak_fill = arc_num;
	endtask

	always @(posedge clk or negedge arst_n) begin
		tet_pkg::tet_rsp_t want;
		if (!arst_n) begin
			arc_num = 0;
			scan_total = '0;
			due_q.delete();
			mismatches = 0;
			rsp_seen = 0;
			peak_fill = 0;
			rsp_due <= 0;
		end else begin
			// A response always belongs to an older request, so it is taken first.
			if (rsp_valid && rsp_ready) begin
				rsp_seen++;
				if (due_q.size() == 0) begin
					$error("response with none due: status %0d, neighbour 0x%0h",
						rsp_item.status, rsp_item.neighbour);
					mismatches++;
				end else begin
					want = due_q.pop_front();
					check_field("status", want.status, rsp_item.status);
					check_field("neighbour", want.neighbour, rsp_item.neighbour);
					check_field("last", want.last, rsp_item.last);
					check_field("edge_total", want.edge_total, rsp_item.edge_total);
					check_field("edges_examined", want.edges_examined, rsp_item.edges_examined);
				end
			end
			if (req_valid && req_ready)
				apply_request(req_item);
			rsp_due <= due_q.size();
		end
	end

endmodule

// File: bench/tb_typed_edge_table.sv
// ----------------------------------------------------------------------------
// Typed edge table testbench
// Drives declare, has, remove and query items into the typed edge table with
// random gaps on both channels, and lets a separate checker predict and
// compare every response. Prints the verdict at the end of the run.
// ----------------------------------------------------------------------------
module tb_typed_edge_table;

	localparam int CAPACITY     = tet_pkg::DEF_CAPACITY;
	localparam int NUM_KINDS    = tet_pkg::DEF_NUM_KINDS;
	localparam int RANDOM_ITEMS = 250;
	// Bound on the whole run. The slowest correct run, with every query giving
	// a full table of neighbours and every response waiting out a long stall,
	// stays well below this.
	localparam int CYCLE_LIMIT  = 1_000_000;
	// The long receiver hold-off, in cycles.
	localparam int LONG_HOLD    = 400;
	localparam int DRAIN_CYCLES = 2 * CAPACITY + 16;
	localparam int RECENT_MAX   = 48;

	logic clk;
	logic arst_n;

	tet_stream_if #(.payload_t(tet_pkg::tet_req_t)) req_ch ();
	tet_stream_if #(.payload_t(tet_pkg::tet_rsp_t)) rsp_ch ();

	int mismatches;
	int rsp_due;
	int rsp_seen;
	int peak_fill;

	// When calm is set neither side inserts gaps. When hold_rsp is set the
	// receiver stops taking responses for the long hold-off.
	bit calm;
	bit hold_rsp;

	// Per-operation item counts, for the summary.
	int sent_by_op[4];

	// Recently declared triples, used to aim has, remove and query items at
	// edges that are likely to be in the table.
	tet_pkg::tet_req_t recent_arcs[$];

	typed_edge_table #(
		.CAPACITY  (CAPACITY),
		.NUM_KINDS (NUM_KINDS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	tet_rsp_checker #(
		.CAPACITY  (CAPACITY),
		.NUM_KINDS (NUM_KINDS)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_ch.valid),
		.req_ready  (req_ch.ready),
		.req_item   (req_ch.payload),
		.rsp_valid  (rsp_ch.valid),
		.rsp_ready  (rsp_ch.ready),
		.rsp_item   (rsp_ch.payload),
		.mismatches (mismatches),
		.rsp_due    (rsp_due),
		.rsp_seen   (rsp_seen),
		.peak_fill  (peak_fill)
	);

	initial clk = 1'b0;
	always #2 clk = ~clk;

	// Gap lengths: mostly none or short, now and then a long one.
	function automatic int pick_gap();
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 24);
	endfunction

	function automatic tet_pkg::tet_req_t make_item(tet_pkg::tet_op_t op, logic [15:0] a,
			logic [3:0] kind, logic [15:0] b, logic [15:0] actor);
		tet_pkg::tet_req_t r;
		r.req_type = op;
		r.node_a = a;
		r.edge_kind = kind;
		r.node_b = b;
		r.actor_id = actor;
		return r;
	endfunction

	// Nodes come mostly from a small pool so that edges collide and queries
	// find several neighbours. A few are null or wide random values.
	function automatic logic [15:0] pick_node();
		int r;
		r = $urandom_range(0, 99);
		if (r < 3)
			return '0;
		if (r < 15)
			return 16'($urandom);
		return 16'($urandom_range(1, 6));
	endfunction

	function automatic logic [3:0] pick_kind();
		if ($urandom_range(0, 99) < 8)
			return 4'($urandom_range(0, 15));
		return 4'($urandom_range(0, 2));
	endfunction

	// Actor 0 is universal; the small pool makes actor filtering matter.
	function automatic logic [15:0] pick_actor();
		int r;
		r = $urandom_range(0, 99);
		if (r < 40)
			return '0;
		if (r < 90)
			return 16'($urandom_range(1, 3));
		return 16'($urandom);
	endfunction

	// One random item. The declare and remove shares shape the phase: a high
	// declare share fills the table, a high remove share drains it. A small
	// share is pure noise over all the fields.
	function automatic tet_pkg::tet_req_t random_item(int declare_pct, int remove_pct);
		tet_pkg::tet_req_t r;
		tet_pkg::tet_req_t aim;
		int                pick;
		pick = $urandom_range(0, 99);
		if ($urandom_range(0, 99) < 5)
			return tet_pkg::tet_req_t'($bits(tet_pkg::tet_req_t)'({$urandom, $urandom}));
		if (pick < declare_pct)
			return make_item(tet_pkg::OP_DECLARE, pick_node(), pick_kind(), pick_node(),
				pick_actor());
		r = make_item(tet_pkg::OP_HAS, pick_node(), pick_kind(), pick_node(), pick_actor());
		if (pick < declare_pct + remove_pct)
			r.req_type = tet_pkg::OP_REMOVE;
		else if ($urandom_range(0, 1) == 1)
			r.req_type = tet_pkg::OP_QUERY;
		if (recent_arcs.size() > 0 && $urandom_range(0, 99) < 70) begin
			aim = recent_arcs[$urandom_range(0, recent_arcs.size() - 1)];
			r.node_a = aim.node_a;
			r.edge_kind = aim.edge_kind;
			r.node_b = aim.node_b;
			// A query may look from either end of the edge.
			if (r.req_type == tet_pkg::OP_QUERY && $urandom_range(0, 1) == 1)
				r.node_a = aim.node_b;
		end
		return r;
	endfunction

	// Offer one item after a random gap and hold it until the block takes it.
	// Valid stays high between back-to-back items, so it is assigned at most
	// once per clock edge.
	task automatic send_item(input tet_pkg::tet_req_t r);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.payload <= r;
		do @(posedge clk); while (!req_ch.ready);
		sent_by_op[r.req_type]++;
		if (r.req_type == tet_pkg::OP_DECLARE) begin
			recent_arcs.push_back(r);
			if (recent_arcs.size() > RECENT_MAX)
				void'(recent_arcs.pop_front());
		end
	endtask

	// Receiver: bursts of ready separated by random gaps, with the one long
	// hold-off whenever the stimulus asks for it.
	initial begin
		rsp_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_rsp) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_rsp = 1'b0;
			end else begin
				int gap;
				rsp_ch.ready <= 1'b1;
				repeat ($urandom_range(1, 16)) @(posedge clk);
				gap = pick_gap();
				if (gap > 0) begin
					rsp_ch.ready <= 1'b0;
					repeat (gap) @(posedge clk);
				end
			end
		end
	end

	// Watchdog: a hung block or a lost response ends the run here.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("Timeout after %0d cycles with %0d responses still due.", CYCLE_LIMIT, rsp_due);
		$display("CHECKS FAILED");
		$finish;
	end

	// Main stimulus.
	initial begin
		calm = 1'b0;
		hold_rsp = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Requests on the empty table must miss without
		// scanning anything.
		send_item(make_item(tet_pkg::OP_QUERY,   16'd1, 4'd0, 16'd0, 16'd0));
		send_item(make_item(tet_pkg::OP_HAS,     16'd1, 4'd0, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_REMOVE,  16'd1, 4'd0, 16'd2, 16'd0));
		// Declares with a null end or a kind out of range are rejected.
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd0, 4'd1, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd1, 4'd1, 16'd0, 16'd0));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd1, 4'(NUM_KINDS), 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd1, 4'hF, 16'd2, 16'd0));
		// Good declares: all-ones fields, a universal edge, an edge owned by
		// actor 7, a self loop and a duplicate of an earlier edge.
		send_item(make_item(tet_pkg::OP_DECLARE, 16'hFFFF, 4'(NUM_KINDS - 1), 16'hFFFF,
			16'hFFFF));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd1, 4'd0, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd2, 4'd0, 16'd3, 16'd7));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd5, 4'd3, 16'd5, 16'd0));
		send_item(make_item(tet_pkg::OP_DECLARE, 16'd1, 4'd0, 16'd2, 16'd0));
		// Queries: several neighbours, the actor filter both ways, a self
		// loop reporting the node itself, a null node and a bad kind.
		send_item(make_item(tet_pkg::OP_QUERY,   16'd2, 4'd0, 16'd0, 16'd7));
		send_item(make_item(tet_pkg::OP_QUERY,   16'd2, 4'd0, 16'd0, 16'd9));
		send_item(make_item(tet_pkg::OP_QUERY,   16'd5, 4'd3, 16'd0, 16'd0));
		send_item(make_item(tet_pkg::OP_QUERY,   16'hFFFF, 4'(NUM_KINDS - 1), 16'd0, 16'd1));
		send_item(make_item(tet_pkg::OP_QUERY,   16'hFFFF, 4'(NUM_KINDS - 1), 16'hFFFF,
			16'hFFFF));
		send_item(make_item(tet_pkg::OP_QUERY,   16'd0, 4'd0, 16'd0, 16'd0));
		send_item(make_item(tet_pkg::OP_QUERY,   16'd1, 4'd12, 16'd0, 16'd0));
		// Has: a hit, a bad kind that scans and misses, and null ends.
		send_item(make_item(tet_pkg::OP_HAS,     16'd1, 4'd0, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_HAS,     16'd1, 4'd12, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_HAS,     16'd0, 4'd0, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_HAS,     16'd1, 4'd0, 16'd0, 16'd0));
		// Remove drops only the newest of the two duplicates.
		send_item(make_item(tet_pkg::OP_REMOVE,  16'd1, 4'd0, 16'd2, 16'd0));
		send_item(make_item(tet_pkg::OP_REMOVE,  16'd0, 4'd0, 16'd1, 16'd0));
		send_item(make_item(tet_pkg::OP_HAS,     16'd2, 4'd0, 16'd3, 16'd0));

		// Random part in three phases: grow until the table is full and
		// declares bounce, churn, then drain with mostly removes. The long
		// receiver hold-off falls in the grow phase, while queries on a
		// well-filled table produce long response trains. One stretch of
		// the churn phase runs without any gaps.
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 60)
				hold_rsp = 1'b1;
			calm = (n >= 110 && n < 150);
			if (n < 90)
				send_item(random_item(70, 8));
			else if (n < 180)
				send_item(random_item(35, 20));
			else
				send_item(random_item(15, 45));
		end
		calm = 1'b0;
		req_ch.valid <= 1'b0;

		// Let the checker see the last accept, then wait for every response
		// and a little longer for anything unexpected.
		@(posedge clk);
		wait (rsp_due == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d declare, %0d has, %0d remove and %0d query items; %0d responses checked.",
			sent_by_op[tet_pkg::OP_DECLARE], sent_by_op[tet_pkg::OP_HAS],
			sent_by_op[tet_pkg::OP_REMOVE], sent_by_op[tet_pkg::OP_QUERY], rsp_seen);
		$display("Table fill peaked at %0d of %0d edges; %0d mismatches.",
			peak_fill, CAPACITY, mismatches);
		if (mismatches == 0 && rsp_due == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
